/* sv/wal_pkg.sv */
// ----------------------------------------------------------------------------
// wal_pkg: shared definitions for the antialiased line rasteriser
// Fixed-point formats, field widths, register indexes and the small
// rounding and brightness helpers.
// ----------------------------------------------------------------------------
package wal_pkg;

	localparam int COORD_FRAC_BITS = 6;
	localparam int COORD_INT_BITS  = 12;
	localparam int SLOPE_FRAC_BITS = 16;

	localparam int CW    = COORD_INT_BITS + COORD_FRAC_BITS;   // endpoint coordinate
	localparam int DW    = CW + 1;                             // coordinate difference
	localparam int PW    = COORD_INT_BITS + 1;                 // pixel coordinate
	localparam int VW    = PW + 1;                             // pixel, with guard bit
	localparam int SW    = SLOPE_FRAC_BITS + 2;                // slope, Q1.16 signed
	localparam int QW    = SLOPE_FRAC_BITS + 1;                // quotient magnitude
	localparam int IW    = PW + SLOPE_FRAC_BITS;               // intercept
	localparam int MBW   = COORD_FRAC_BITS + 2;                // narrow multiplier operand
	localparam int GAPW  = COORD_FRAC_BITS + 1;                // x gap
	localparam int PRW   = SW + MBW;                           // product
	localparam int EPCW  = SLOPE_FRAC_BITS + COORD_FRAC_BITS + 1;
	localparam int CNTW  = $clog2(QW);
	localparam int DIMW  = 12;
	localparam int BW    = 8;
	localparam int SLOPE_SHIFT = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
	localparam int COORD_HALF  = 1 << (COORD_FRAC_BITS - 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [DIMW-1:0] SCREEN_WIDTH_RST  = DIMW'(1024);
	localparam logic [DIMW-1:0] SCREEN_HEIGHT_RST = DIMW'(768);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// round half away from zero to a whole pixel
	function automatic logic signed [PW-1:0] rnd_coord(input logic signed [CW-1:0] v);
		logic signed [DW-1:0] ve;
		logic [DW-1:0] mag;
		logic [DW-1:0] r;
		ve  = DW'(v);
		mag = ve[DW-1] ? -ve : ve;
		r   = (mag + DW'(COORD_HALF)) >> COORD_FRAC_BITS;
		return ve[DW-1] ? -PW'(r) : PW'(r);
	endfunction

	// coverage with SLOPE+COORD fraction bits -> 0..255
	function automatic logic [BW-1:0] bright_ep(input logic [EPCW-1:0] c);
		logic [EPCW+8:0] t;
		logic [EPCW+8-(SLOPE_FRAC_BITS+COORD_FRAC_BITS):0] b;
		t = {1'b0, c, 8'b0} - (EPCW+9)'(c)
		    + (EPCW+9)'(1 << (SLOPE_FRAC_BITS + COORD_FRAC_BITS - 1));
		b = t[EPCW+8:SLOPE_FRAC_BITS+COORD_FRAC_BITS];
		return (b > 255) ? 8'hFF : b[BW-1:0];
	endfunction

	// coverage with SLOPE fraction bits -> 0..255
	function automatic logic [BW-1:0] bright_in(input logic [QW-1:0] c);
		logic [QW+8:0] t;
		logic [QW+8-SLOPE_FRAC_BITS:0] b;
		t = {1'b0, c, 8'b0} - (QW+9)'(c) + (QW+9)'(1 << (SLOPE_FRAC_BITS - 1));
		b = t[QW+8:SLOPE_FRAC_BITS];
		return (b > 255) ? 8'hFF : b[BW-1:0];
	endfunction

endpackage

/* sv/wal_if.sv */
// ----------------------------------------------------------------------------
// wal_if: valid/ready channels of the antialiased line rasteriser
// Command words in, pixel words out.
// ----------------------------------------------------------------------------
interface wal_in_if import wal_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic signed [CW-1:0] start_x;
	logic signed [CW-1:0] start_y;
	logic signed [CW-1:0] end_x;
	logic signed [CW-1:0] end_y;

	modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface wal_out_if import wal_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [PW-1:0] pixel_x;
	logic signed [PW-1:0] pixel_y;
	logic [BW-1:0]        brightness;
	logic                 visible;
	logic                 run_last;
	logic                 line_done;

	modport source (output valid, pixel_x, pixel_y, brightness, visible, run_last,
		line_done, input ready);
	modport sink   (input valid, pixel_x, pixel_y, brightness, visible, run_last,
		line_done, output ready);
endinterface

/* sv/wu_antialiased_line_top.sv */
// ----------------------------------------------------------------------------
// wu_antialiased_line_top: Wu antialiased line rasteriser, fixed point
// Sequenced datapath around one divider step and one shared multiplier.
// ----------------------------------------------------------------------------
// A load word (cmd 0) carries two Q12.6 endpoints. The block swaps the axes
// for steep lines, orders the endpoints so the major coordinate grows, forms
// the Q1.16 gradient with a restoring divider (one quotient bit per cycle)
// and then emits the four endpoint pixels weighted by their x gaps. A load
// takes the word, swaps and orders the endpoints, runs the divider, places
// both endpoints on the minor axis through the shared multiplier, and then
// multiplies and emits each endpoint pixel in turn. A step word (cmd 1)
// emits the two pixels of the next interior column, one per cycle through
// the single output register while that register is free; a step with no
// line loaded is swallowed with no pixels. Equal endpoints give one
// full-brightness pixel. Off-screen pixels are still emitted, with visible
// low. The input is ready only while the sequencer is idle; the last pixel
// may still sit in the output register while the next word is taken.
// screen_width and screen_height are written through cfg_we/cfg_index/
// cfg_data; the user must write them while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module wu_antialiased_line_top import wal_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	wal_in_if.sink               line_in,
	wal_out_if.source            pix_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIMW-1:0]      cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SWAP,   // steep test and axis swap
		S_ORDER,  // endpoint order, dx and |dy|
		S_ZERO,   // degenerate line: single pixel
		S_DIV,    // one quotient bit a cycle
		S_YSR,    // round endpoint, x offset and gap
		S_YSM,    // slope * offset
		S_YSA,    // minor coordinate at rounded x
		S_EPM,    // endpoint coverage product
		S_EPO,    // endpoint pixel out
		S_STEP    // interior column, two pixels
	} state_t;

	state_t state_q;

	// screen size registers
	logic [DIMW-1:0] screen_width_q;
	logic [DIMW-1:0] screen_height_q;

	// line set-up
	logic signed [CW-1:0]   x0_q, y0_q, x1_q, y1_q;
	logic                   steep_q;
	logic                   active_q;
	logic                   inner_q;
	logic                   ep_q;
	logic                   dyneg_q;
	logic [DW-1:0]          dx_q;
	logic [DW:0]            rem_q;
	logic [QW-1:0]          quo_q;
	logic [CNTW-1:0]        cnt_q;
	logic signed [SW-1:0]   slope_q;
	logic signed [PW-1:0]   xr1_q, xr2_q;
	logic signed [MBW-1:0]  mdelta_q;
	logic [GAPW-1:0]        gap1_q, gap2_q;
	logic signed [PRW-1:0]  prod_q;
	logic signed [IW-1:0]   ys1_q, ys2_q;
	logic signed [IW-1:0]   intercept_q;
	logic signed [PW-1:0]   column_q, last_column_q;
	logic [1:0]             pix_idx_q;

	// output register
	logic                   out_valid_q;
	logic signed [PW-1:0]   out_x_q, out_y_q;
	logic [BW-1:0]          out_bright_q;
	logic                   out_vis_q, out_last_q, out_done_q;

	// ---------------- combinational datapath ----------------
	logic                   slot_free;

	// swap stage
	logic signed [DW-1:0]   sw_ddx, sw_ddy;
	logic [DW-1:0]          sw_adx, sw_ady;
	logic                   sw_steep;

	// order stage
	logic                   or_swap;
	logic signed [CW-1:0]   or_a0, or_b0, or_a1, or_b1;
	logic signed [DW-1:0]   or_dx, or_dy;

	// divider step
	logic [DW:0]            dv_trial, dv_diff;
	logic                   dv_ge;
	logic [QW-1:0]          dv_quo;

	// endpoint placement
	logic signed [CW-1:0]   ys_x, ys_y;
	logic signed [PW-1:0]   ys_xr;
	logic [COORD_FRAC_BITS-1:0] ys_low;
	logic signed [IW-1:0]   ys_sum;

	// shared multiplier
	logic signed [SW-1:0]   mul_a;
	logic signed [MBW-1:0]  mul_b;
	logic signed [PRW-1:0]  mul_p;

	// pixel emission
	logic signed [IW-1:0]   ep_ys;
	logic [SLOPE_FRAC_BITS-1:0] ep_fy;
	logic [QW-1:0]          ep_cov;
	logic [SLOPE_FRAC_BITS-1:0] st_f;
	logic                   st_done;
	logic                   em_fire;
	logic signed [VW-1:0]   em_major, em_minor;
	logic [BW-1:0]          em_bright;
	logic                   em_last, em_done;
	logic signed [VW-1:0]   em_px, em_py;
	logic                   em_vis;

	assign slot_free     = !out_valid_q || pix_out.ready;
	assign line_in.ready = (state_q == S_IDLE);

	// steep test: |dy| > |dx|
	always_comb begin
		sw_ddx   = DW'(x1_q) - DW'(x0_q);
		sw_ddy   = DW'(y1_q) - DW'(y0_q);
		sw_adx   = sw_ddx[DW-1] ? -sw_ddx : sw_ddx;
		sw_ady   = sw_ddy[DW-1] ? -sw_ddy : sw_ddy;
		sw_steep = sw_ady > sw_adx;
	end

	// ordering so that the major coordinate grows
	always_comb begin
		or_swap = x0_q > x1_q;
		or_a0   = or_swap ? x1_q : x0_q;
		or_b0   = or_swap ? y1_q : y0_q;
		or_a1   = or_swap ? x0_q : x1_q;
		or_b1   = or_swap ? y0_q : y1_q;
		or_dx   = DW'(or_a1) - DW'(or_a0);
		or_dy   = DW'(or_b1) - DW'(or_b0);
	end

	// restoring divider: no shift on the first step, |dy| <= dx
	always_comb begin
		dv_trial = (cnt_q == '0) ? rem_q : {rem_q[DW-1:0], 1'b0};
		dv_diff  = dv_trial - {1'b0, dx_q};
		dv_ge    = dv_trial >= {1'b0, dx_q};
		dv_quo   = {quo_q[QW-2:0], dv_ge};
	end

	// endpoint on the minor axis
	always_comb begin
		ys_x   = ep_q ? x1_q : x0_q;
		ys_y   = ep_q ? y1_q : y0_q;
		ys_xr  = rnd_coord(ys_x);
		ys_low = ys_x[COORD_FRAC_BITS-1:0] + COORD_FRAC_BITS'(COORD_HALF);
		ys_sum = (IW'(ys_y) <<< SLOPE_SHIFT) + IW'(prod_q >>> COORD_FRAC_BITS);
	end

	// endpoint coverage terms
	always_comb begin
		ep_ys  = pix_idx_q[1] ? ys2_q : ys1_q;
		ep_fy  = ep_ys[SLOPE_FRAC_BITS-1:0];
		ep_cov = pix_idx_q[0] ? {1'b0, ep_fy}
		                      : QW'(1 << SLOPE_FRAC_BITS) - {1'b0, ep_fy};
	end

	// the one multiplier, shared between placement and coverage
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_YSM: begin
				mul_a = slope_q;
				mul_b = mdelta_q;
			end
			S_EPM: begin
				mul_a = SW'(ep_cov);
				mul_b = MBW'(pix_idx_q[1] ? gap2_q : gap1_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// pixel selection
	always_comb begin
		st_f      = intercept_q[SLOPE_FRAC_BITS-1:0];
		st_done   = (VW'(column_q) + VW'(1)) >= VW'(last_column_q);
		em_fire   = 1'b0;
		em_major  = '0;
		em_minor  = '0;
		em_bright = '0;
		em_last   = 1'b0;
		em_done   = 1'b0;
		case (state_q)
			S_ZERO: begin
				em_fire   = slot_free;
				em_major  = VW'(rnd_coord(x0_q));
				em_minor  = VW'(rnd_coord(y0_q));
				em_bright = 8'hFF;
				em_last   = 1'b1;
				em_done   = 1'b1;
			end
			S_EPO: begin
				em_fire   = slot_free;
				em_major  = VW'(pix_idx_q[1] ? xr2_q : xr1_q);
				em_minor  = VW'(signed'(ep_ys[IW-1:SLOPE_FRAC_BITS]))
				            + {{(VW-1){1'b0}}, pix_idx_q[0]};
				em_bright = bright_ep(prod_q[EPCW-1:0]);
				em_last   = (pix_idx_q == 2'd3);
				em_done   = (pix_idx_q == 2'd3) && !inner_q;
			end
			S_STEP: begin
				em_fire   = slot_free;
				em_major  = VW'(column_q);
				em_minor  = VW'(signed'(intercept_q[IW-1:SLOPE_FRAC_BITS]))
				            + {{(VW-1){1'b0}}, pix_idx_q[0]};
				em_bright = bright_in(pix_idx_q[0] ? {1'b0, st_f}
				                      : QW'(1 << SLOPE_FRAC_BITS) - {1'b0, st_f});
				em_last   = pix_idx_q[0];
				em_done   = pix_idx_q[0] && st_done;
			end
			default: begin
				em_fire = 1'b0;
			end
		endcase
		em_px  = steep_q ? em_minor : em_major;
		em_py  = steep_q ? em_major : em_minor;
		em_vis = !em_px[VW-1] && !em_py[VW-1]
		         && (em_px < VW'(screen_width_q)) && (em_py < VW'(screen_height_q));
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			x0_q          <= '0;
			y0_q          <= '0;
			x1_q          <= '0;
			y1_q          <= '0;
			steep_q       <= 1'b0;
			active_q      <= 1'b0;
			inner_q       <= 1'b0;
			ep_q          <= 1'b0;
			dyneg_q       <= 1'b0;
			dx_q          <= '0;
			rem_q         <= '0;
			quo_q         <= '0;
			cnt_q         <= '0;
			slope_q       <= '0;
			xr1_q         <= '0;
			xr2_q         <= '0;
			mdelta_q      <= '0;
			gap1_q        <= '0;
			gap2_q        <= '0;
			prod_q        <= '0;
			ys1_q         <= '0;
			ys2_q         <= '0;
			intercept_q   <= '0;
			column_q      <= '0;
			last_column_q <= '0;
			pix_idx_q     <= '0;
			out_valid_q   <= 1'b0;
			out_x_q       <= '0;
			out_y_q       <= '0;
			out_bright_q  <= '0;
			out_vis_q     <= 1'b0;
			out_last_q    <= 1'b0;
			out_done_q    <= 1'b0;
		end else begin
			// output register
			if (em_fire) begin
				out_valid_q  <= 1'b1;
				out_x_q      <= em_px[PW-1:0];
				out_y_q      <= em_py[PW-1:0];
				out_bright_q <= em_bright;
				out_vis_q    <= em_vis;
				out_last_q   <= em_last;
				out_done_q   <= em_done;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (line_in.valid) begin
						if (line_in.cmd == CMD_STEP) begin
							if (active_q) begin
								pix_idx_q <= 2'd0;
								state_q   <= S_STEP;
							end
						end else begin
							x0_q     <= line_in.start_x;
							y0_q     <= line_in.start_y;
							x1_q     <= line_in.end_x;
							y1_q     <= line_in.end_y;
							active_q <= 1'b0;
							state_q  <= S_SWAP;
						end
					end
				end
				S_SWAP: begin
					steep_q <= sw_steep;
					if (sw_steep) begin
						x0_q <= y0_q;
						y0_q <= x0_q;
						x1_q <= y1_q;
						y1_q <= x1_q;
					end
					state_q <= S_ORDER;
				end
				S_ORDER: begin
					x0_q    <= or_a0;
					y0_q    <= or_b0;
					x1_q    <= or_a1;
					y1_q    <= or_b1;
					dx_q    <= or_dx;
					dyneg_q <= or_dy[DW-1];
					rem_q   <= (DW+1)'(or_dy[DW-1] ? -or_dy : or_dy);
					cnt_q   <= '0;
					state_q <= (or_dx == '0) ? S_ZERO : S_DIV;
				end
				S_ZERO: begin
					if (em_fire)
						state_q <= S_IDLE;
				end
				S_DIV: begin
					rem_q <= dv_ge ? dv_diff : dv_trial;
					quo_q <= dv_quo;
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(SLOPE_FRAC_BITS)) begin
						slope_q <= dyneg_q ? -SW'(dv_quo) : SW'(dv_quo);
						ep_q    <= 1'b0;
						state_q <= S_YSR;
					end
				end
				S_YSR: begin
					mdelta_q <= MBW'((DW'(ys_xr) <<< COORD_FRAC_BITS) - DW'(ys_x));
					if (ep_q) begin
						xr2_q  <= ys_xr;
						gap2_q <= {1'b0, ys_low};
					end else begin
						xr1_q  <= ys_xr;
						gap1_q <= GAPW'(1 << COORD_FRAC_BITS) - {1'b0, ys_low};
					end
					state_q <= S_YSM;
				end
				S_YSM: begin
					prod_q  <= mul_p;
					state_q <= S_YSA;
				end
				S_YSA: begin
					if (ep_q) begin
						ys2_q         <= ys_sum;
						intercept_q   <= ys1_q + IW'(slope_q);
						column_q      <= xr1_q + PW'(1);
						last_column_q <= xr2_q;
						inner_q       <= (xr1_q + PW'(1)) < xr2_q;
						active_q      <= (xr1_q + PW'(1)) < xr2_q;
						pix_idx_q     <= 2'd0;
						state_q       <= S_EPM;
					end else begin
						ys1_q   <= ys_sum;
						ep_q    <= 1'b1;
						state_q <= S_YSR;
					end
				end
				S_EPM: begin
					prod_q  <= mul_p;
					state_q <= S_EPO;
				end
				S_EPO: begin
					if (em_fire) begin
						pix_idx_q <= pix_idx_q + 2'd1;
						state_q   <= (pix_idx_q == 2'd3) ? S_IDLE : S_EPM;
					end
				end
				S_STEP: begin
					if (em_fire) begin
						pix_idx_q <= pix_idx_q + 2'd1;
						if (pix_idx_q[0]) begin
							intercept_q <= intercept_q + IW'(slope_q);
							column_q    <= column_q + PW'(1);
							active_q    <= !st_done;
							state_q     <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.pixel_x    = out_x_q;
	assign pix_out.pixel_y    = out_y_q;
	assign pix_out.brightness = out_bright_q;
	assign pix_out.visible    = out_vis_q;
	assign pix_out.run_last   = out_last_q;
	assign pix_out.line_done  = out_done_q;

endmodule
